### sv/pfp_pkg.sv
// shared types and constants of the polygon face plane unit
package pfp_pkg;

  localparam int COORD_W = 16;
  localparam int CNT_W   = 9;
  localparam int CSUM_W  = 25;
  localparam int NSUM_W  = 42;
  localparam int MAG_W   = 41;
  localparam int HALF_W  = 21;
  localparam int SQ_W    = 84;
  localparam int ROOT_W  = 42;
  localparam int REM_W   = 46;
  localparam int Q_W     = 17;
  localparam int DIV_W   = 64;
  localparam int AREA_W  = 40;
  localparam int NORM_FRAC = 14;

  // one closed face handed from the front to the back
  typedef struct packed {
    logic signed [NSUM_W-1:0] nsum_x;
    logic signed [NSUM_W-1:0] nsum_y;
    logic signed [NSUM_W-1:0] nsum_z;
    logic signed [CSUM_W-1:0] csum_x;
    logic signed [CSUM_W-1:0] csum_y;
    logic signed [CSUM_W-1:0] csum_z;
    logic [CNT_W-1:0]         count;
  } face_job_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### sv/pfp_front.sv
// front end: vertex accumulation and newell sums
module pfp_front #(
  parameter int MAX_FACE_VERTICES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pfp_pkg::COORD_W-1:0]  vx,
  input  logic signed [pfp_pkg::COORD_W-1:0]  vy,
  input  logic signed [pfp_pkg::COORD_W-1:0]  vz,
  input  logic                                last_vertex,
  input  pfp_pkg::queue_status_t              q_status,
  output logic                                push,
  output pfp_pkg::face_job_t                  push_job
);

  localparam int CW = pfp_pkg::COORD_W;
  localparam int NW = pfp_pkg::NSUM_W;
  localparam int SW = pfp_pkg::CSUM_W;

  logic signed [CW-1:0] first_x, first_y, first_z;
  logic signed [CW-1:0] prev_x, prev_y, prev_z;
  logic [pfp_pkg::CNT_W-1:0] count;
  logic signed [SW-1:0] csum_x, csum_y, csum_z;
  logic signed [NW-1:0] nsum_x, nsum_y, nsum_z;
  logic closing;

  logic accept, active, add_open;
  logic signed [CW-1:0] p2_x, p2_y, p2_z;
  logic signed [CW:0] dx, dy, dz, sx, sy, sz;
  logic signed [2*CW+1:0] ex, ey, ez;
  logic signed [NW-1:0] nx_new, ny_new, nz_new;

  assign in_stall = closing;
  assign accept   = in_valid && !closing;
  assign active   = count < pfp_pkg::CNT_W'(MAX_FACE_VERTICES);
  assign add_open = accept && active && (count != '0);
  assign push     = closing && !q_status.full;

  // edge from prev to either the new vertex or, when closing, the first one
  always_comb begin
    if (closing) begin
      p2_x = first_x; p2_y = first_y; p2_z = first_z;
    end else begin
      p2_x = vx; p2_y = vy; p2_z = vz;
    end
    dx = (CW+1)'(prev_x) - (CW+1)'(p2_x);
    dy = (CW+1)'(prev_y) - (CW+1)'(p2_y);
    dz = (CW+1)'(prev_z) - (CW+1)'(p2_z);
    sx = (CW+1)'(prev_x) + (CW+1)'(p2_x);
    sy = (CW+1)'(prev_y) + (CW+1)'(p2_y);
    sz = (CW+1)'(prev_z) + (CW+1)'(p2_z);
    ex = dy * sz;
    ey = dz * sx;
    ez = dx * sy;
    nx_new = nsum_x + NW'(ex);
    ny_new = nsum_y + NW'(ey);
    nz_new = nsum_z + NW'(ez);
  end

  always_comb begin
    push_job.nsum_x = nx_new;
    push_job.nsum_y = ny_new;
    push_job.nsum_z = nz_new;
    push_job.csum_x = csum_x;
    push_job.csum_y = csum_y;
    push_job.csum_z = csum_z;
    push_job.count  = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      closing <= 1'b0;
      count   <= '0;
      first_x <= '0; first_y <= '0; first_z <= '0;
      prev_x  <= '0; prev_y  <= '0; prev_z  <= '0;
      csum_x  <= '0; csum_y  <= '0; csum_z  <= '0;
      nsum_x  <= '0; nsum_y  <= '0; nsum_z  <= '0;
    end else if (push) begin
      closing <= 1'b0;
      count   <= '0;
      first_x <= '0; first_y <= '0; first_z <= '0;
      prev_x  <= '0; prev_y  <= '0; prev_z  <= '0;
      csum_x  <= '0; csum_y  <= '0; csum_z  <= '0;
      nsum_x  <= '0; nsum_y  <= '0; nsum_z  <= '0;
    end else if (accept) begin
      if (active) begin
        if (count == '0) begin
          first_x <= vx; first_y <= vy; first_z <= vz;
        end
        prev_x <= vx; prev_y <= vy; prev_z <= vz;
        csum_x <= csum_x + SW'(vx);
        csum_y <= csum_y + SW'(vy);
        csum_z <= csum_z + SW'(vz);
        count  <= count + 1'b1;
      end
      if (add_open) begin
        nsum_x <= nx_new; nsum_y <= ny_new; nsum_z <= nz_new;
      end
      closing <= last_vertex;
    end
  end

endmodule

### sv/pfp_queue.sv
// two-entry queue of closed faces between front and back
module pfp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pfp_pkg::face_job_t     push_job,
  input  logic                   pop,
  output pfp_pkg::face_job_t     pop_job,
  output pfp_pkg::queue_status_t status
);

  pfp_pkg::face_job_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign status.full  = fill == 2'd2;
  assign status.empty = fill == 2'd0;
  assign pop_job      = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule

### sv/pfp_back.sv
// back end: squared length, square root and rounding divisions
module pfp_back (
  input  logic                               clk,
  input  logic                               rst,
  input  pfp_pkg::queue_status_t             q_status,
  input  pfp_pkg::face_job_t                 pop_job,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [15:0]                 norm_x,
  output logic signed [15:0]                 norm_y,
  output logic signed [15:0]                 norm_z,
  output logic signed [15:0]                 cent_x,
  output logic signed [15:0]                 cent_y,
  output logic signed [15:0]                 cent_z,
  output logic [pfp_pkg::AREA_W-1:0]         face_area,
  output logic                               degenerate
);

  localparam int MW = pfp_pkg::MAG_W;
  localparam int HW = pfp_pkg::HALF_W;
  localparam int SQW = pfp_pkg::SQ_W;
  localparam int RW = pfp_pkg::ROOT_W;
  localparam int EW = pfp_pkg::REM_W;
  localparam int QW = pfp_pkg::Q_W;
  localparam int DW = pfp_pkg::DIV_W;
  localparam int AW = pfp_pkg::AREA_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_DSET = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [1:0] PART_LO  = 2'd0;
  localparam logic [1:0] PART_MID = 2'd1;
  localparam logic [1:0] PART_HI  = 2'd2;

  logic [2:0] state;
  pfp_pkg::face_job_t job;
  logic [MW-1:0] mag [3];
  logic          neg [3];
  logic [1:0]    comp, part;
  logic [SQW-1:0] acc, s_sh;
  logic [EW-1:0]  rem;
  logic [RW-1:0]  root;
  logic [5:0]     iter;
  logic [2:0]     idx;
  logic [DW-1:0]  r, dsh;
  logic [QW-1:0]  q;
  logic [4:0]     dcnt;
  logic           dneg;
  logic [15:0]    res [6];
  logic           res_deg;

  logic [MW-1:0]  sq_mag;
  logic [HW-1:0]  ma, mb;
  logic [2*HW-1:0] prod;
  logic [SQW-1:0] prod_sh;
  logic [EW-1:0]  rem_sh, trial;
  logic           take;
  logic [DW-1:0]  num_set, den_set;
  logic           neg_set;
  logic signed [pfp_pkg::CSUM_W-1:0] csel;
  logic [pfp_pkg::CSUM_W-1:0] cmag;
  logic [QW-1:0]  qn;
  logic [QW-1:0]  qs;
  logic           deg_in;
  logic           load_out;

  assign pop    = (state == ST_IDLE) && !q_status.empty;
  assign deg_in = (pop_job.count < pfp_pkg::CNT_W'(3)) ||
                  (pop_job.nsum_x == '0 && pop_job.nsum_y == '0 && pop_job.nsum_z == '0);
  // output register free, or emptied by a beat this cycle
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  // squaring one magnitude as three partial products
  always_comb begin
    sq_mag = mag[comp];
    ma = sq_mag[HW-1:0];
    mb = {1'b0, sq_mag[MW-1:HW]};
    unique case (part)
      PART_LO:  prod = ma * ma;
      PART_MID: prod = ma * mb;
      PART_HI:  prod = mb * mb;
      default:  prod = '0;
    endcase
    unique case (part)
      PART_LO:  prod_sh = SQW'(prod);
      PART_MID: prod_sh = SQW'(prod) << (HW + 1);
      PART_HI:  prod_sh = SQW'(prod) << (2 * HW);
      default:  prod_sh = '0;
    endcase
  end

  // restoring square root, two radicand bits per step
  always_comb begin
    rem_sh = {rem[EW-3:0], s_sh[SQW-1:SQW-2]};
    trial  = EW'({root, 2'b01});
    take   = rem_sh >= trial;
  end

  // dividend and divisor for the next rounding division
  always_comb begin
    csel = job.csum_x;
    unique case (idx)
      3'd3:    csel = job.csum_x;
      3'd4:    csel = job.csum_y;
      3'd5:    csel = job.csum_z;
      default: csel = job.csum_x;
    endcase
    cmag = csel[pfp_pkg::CSUM_W-1] ? -csel : csel;
    if (idx < 3'd3) begin
      num_set = (DW'(mag[idx[1:0]]) << (pfp_pkg::NORM_FRAC + 1)) + DW'(root);
      den_set = DW'(root) << 1;
      neg_set = neg[idx[1:0]];
    end else begin
      num_set = (DW'(cmag) << 1) + DW'(job.count);
      den_set = DW'(job.count) << 1;
      neg_set = csel[pfp_pkg::CSUM_W-1];
    end
  end

  always_comb begin
    qn = {q[QW-2:0], r >= dsh};
    qs = dneg ? -qn : qn;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= pop_job;
      neg[0] <= pop_job.nsum_x[pfp_pkg::NSUM_W-1];
      neg[1] <= pop_job.nsum_y[pfp_pkg::NSUM_W-1];
      neg[2] <= pop_job.nsum_z[pfp_pkg::NSUM_W-1];
      mag[0] <= MW'(pop_job.nsum_x[pfp_pkg::NSUM_W-1] ? -pop_job.nsum_x : pop_job.nsum_x);
      mag[1] <= MW'(pop_job.nsum_y[pfp_pkg::NSUM_W-1] ? -pop_job.nsum_y : pop_job.nsum_y);
      mag[2] <= MW'(pop_job.nsum_z[pfp_pkg::NSUM_W-1] ? -pop_job.nsum_z : pop_job.nsum_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            comp <= 2'd0;
            part <= PART_LO;
            acc  <= '0;
            res_deg <= deg_in;
            state <= deg_in ? ST_DONE : ST_SQR;
          end
        end
        ST_SQR: begin
          acc <= acc + prod_sh;
          if (part == PART_HI) begin
            part <= PART_LO;
            if (comp == 2'd2) begin
              s_sh  <= acc + prod_sh;
              rem   <= '0;
              root  <= '0;
              iter  <= 6'(RW - 1);
              state <= ST_ROOT;
            end else begin
              comp <= comp + 2'd1;
            end
          end else begin
            part <= part + 2'd1;
          end
        end
        ST_ROOT: begin
          s_sh <= s_sh << 2;
          rem  <= take ? rem_sh - trial : rem_sh;
          root <= {root[RW-2:0], take};
          if (iter == '0) begin
            idx   <= 3'd0;
            state <= ST_DSET;
          end else begin
            iter <= iter - 6'd1;
          end
        end
        ST_DSET: begin
          r     <= num_set;
          dsh   <= den_set << (QW - 1);
          dneg  <= neg_set;
          q     <= '0;
          dcnt  <= 5'(QW - 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (r >= dsh) r <= r - dsh;
          dsh <= dsh >> 1;
          q   <= qn;
          if (dcnt == '0) begin
            res[idx] <= qs[15:0];
            if (idx == 3'd5) begin
              state <= ST_DONE;
            end else begin
              idx   <= idx + 3'd1;
              state <= ST_DSET;
            end
          end else begin
            dcnt <= dcnt - 5'd1;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            degenerate <= res_deg;
            if (res_deg) begin
              norm_x <= '0; norm_y <= '0; norm_z <= '0;
              cent_x <= '0; cent_y <= '0; cent_z <= '0;
              face_area <= '0;
            end else begin
              norm_x <= res[0]; norm_y <= res[1]; norm_z <= res[2];
              cent_x <= res[3]; cent_y <= res[4]; cent_z <= res[5];
              face_area <= root[RW-1] ? '1 : AW'(root >> 1);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### sv/polygon_face_plane_unit.sv
// top level of the polygon face plane unit
//
//   channel  direction  handshake            beat
//   in       sink       in_valid / in_stall  one vertex: vx, vy, vz, last_vertex
//   out      source     out_valid / out_stall one face: normal, centroid, area, flag
//
// vertices are taken one per cycle while in_stall is low; after a marked vertex
// the input stalls while the front closes the face, until the queue has room.
// the back end works on one face at a time, paced by the shared squaring
// multiplier, the bit-serial square root and the one-bit-a-step divider (a
// degenerate face skips all three); it pops a new face only once the last is in
// its output register. a two-face queue lets the front carry on meanwhile.
// reset is synchronous and clears the face accumulators, queue and back end.
module polygon_face_plane_unit #(
  parameter int MAX_FACE_VERTICES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [pfp_pkg::COORD_W-1:0]  vx,
  input  logic signed [pfp_pkg::COORD_W-1:0]  vy,
  input  logic signed [pfp_pkg::COORD_W-1:0]  vz,
  input  logic                                last_vertex,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [15:0]                  norm_x,
  output logic signed [15:0]                  norm_y,
  output logic signed [15:0]                  norm_z,
  output logic signed [15:0]                  cent_x,
  output logic signed [15:0]                  cent_y,
  output logic signed [15:0]                  cent_z,
  output logic [pfp_pkg::AREA_W-1:0]          face_area,
  output logic                                degenerate
);

  // front to queue
  logic               push;
  pfp_pkg::face_job_t push_job;
  // queue to back
  logic               pop;
  pfp_pkg::face_job_t pop_job;
  pfp_pkg::queue_status_t q_status;

  // accumulates newell and coordinate sums, closes the face on the mark
  pfp_front #(
    .MAX_FACE_VERTICES (MAX_FACE_VERTICES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .vx          (vx),
    .vy          (vy),
    .vz          (vz),
    .last_vertex (last_vertex),
    .q_status    (q_status),
    .push        (push),
    .push_job    (push_job)
  );

  // decouples the front from the long back end
  pfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  // length, unit normal, centroid and area, with an output register
  pfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .cent_x     (cent_x),
    .cent_y     (cent_y),
    .cent_z     (cent_z),
    .face_area  (face_area),
    .degenerate (degenerate)
  );

endmodule
